// File: sv/rpdt_pkg.sv
// ----------------------------------------------------------------------------
// rpdt_pkg
// Shared types and constants for the rssi proximity door trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package rpdt_pkg;

  // trend encoding
  typedef enum logic [1:0] {
    TREND_UNKNOWN  = 2'd0,
    TREND_RECEDE   = 2'd1,
    TREND_APPROACH = 2'd2
  } trend_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEDE_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_COUNT   = 3'd5;

  // threshold level codes
  localparam logic [2:0] LEVEL_1 = 3'd1;
  localparam logic [2:0] LEVEL_2 = 3'd2;
  localparam logic [2:0] LEVEL_3 = 3'd3;

  // open thresholds (sample must be above)
  localparam logic signed [7:0] OPEN_THR_1 = -8'sd68;
  localparam logic signed [7:0] OPEN_THR_2 = -8'sd80;
  localparam logic signed [7:0] OPEN_THR_3 = -8'sd85;

  // close thresholds (sample must be below)
  localparam logic signed [7:0] CLOSE_THR_1 = -8'sd80;
  localparam logic signed [7:0] CLOSE_THR_2 = -8'sd90;
  localparam logic signed [7:0] CLOSE_THR_3 = -8'sd95;

  // time handling
  localparam int unsigned TIME_W = 27;
  localparam logic [TIME_W:0] WRAP_SPAN = 28'h4FFFFFF;
  localparam logic [TIME_W:0] HOLD_MS   = 28'd1000;

  // input beat
  typedef struct packed {
    logic signed [7:0]  rssi;
    logic [TIME_W-1:0]  now_ms;
  } in_t;

  // result beat
  typedef struct packed {
    logic       event_valid;
    logic       open_door;
    logic [1:0] trend;
  } out_t;

  // configuration register set
  typedef struct packed {
    logic       link_ready;
    logic       auto_enable;
    logic [2:0] approach_level;
    logic [2:0] recede_level;
    logic [7:0] confirm_count;
    logic [7:0] switch_count;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/rpdt_cfg.sv
// ----------------------------------------------------------------------------
// rpdt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdt_cfg
  import rpdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LINK_READY:     cfg_nxt.link_ready     = cfg_wdata[0];
        CFG_AUTO_ENABLE:    cfg_nxt.auto_enable    = cfg_wdata[0];
        CFG_APPROACH_LEVEL: cfg_nxt.approach_level = cfg_wdata[2:0];
        CFG_RECEDE_LEVEL:   cfg_nxt.recede_level   = cfg_wdata[2:0];
        CFG_CONFIRM_COUNT:  cfg_nxt.confirm_count  = cfg_wdata;
        CFG_SWITCH_COUNT:   cfg_nxt.switch_count   = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // register with reset defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_ready     <= 1'b0;
      cfg_r.auto_enable    <= 1'b1;
      cfg_r.approach_level <= LEVEL_1;
      cfg_r.recede_level   <= LEVEL_1;
      cfg_r.confirm_count  <= 8'd5;
      cfg_r.switch_count   <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: sv/rpdt_core.sv
// ----------------------------------------------------------------------------
// rpdt_core
// Trend tracking state and door decision for one sample per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdt_core
  import rpdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      res
);

  logic signed [7:0] last_rssi_r, last_rssi_nxt;
  trend_t            trend_r, trend_nxt;
  logic [7:0]        appr_cnt_r, appr_cnt_nxt;
  logic [7:0]        rec_cnt_r, rec_cnt_nxt;
  logic              door_open_r, door_open_nxt;
  logic [TIME_W-1:0] tct_r, tct_nxt;

  logic              active;
  logic              rise, fall;
  logic [7:0]        appr_inc, rec_inc;
  logic [TIME_W:0]   now_x, tct_x, elapsed;
  logic              hold_done;
  logic              open_hit, close_hit;

  assign active   = cfg.link_ready & cfg.auto_enable;
  assign rise     = item.rssi > last_rssi_r;
  assign fall     = item.rssi < last_rssi_r;
  assign appr_inc = appr_cnt_r + 8'd1;
  assign rec_inc  = rec_cnt_r + 8'd1;

  // trend counters and switching
  always_comb begin
    last_rssi_nxt = last_rssi_r;
    trend_nxt     = trend_r;
    appr_cnt_nxt  = appr_cnt_r;
    rec_cnt_nxt   = rec_cnt_r;
    tct_nxt       = tct_r;
    if (!active) begin
      appr_cnt_nxt = 8'd0;
      rec_cnt_nxt  = 8'd0;
    end else begin
      priority if (rise && (trend_r == TREND_UNKNOWN || trend_r == TREND_RECEDE)) begin
        appr_cnt_nxt = appr_inc;
        if (appr_inc > cfg.confirm_count) rec_cnt_nxt = 8'd0;
        if (appr_inc > cfg.switch_count) begin
          appr_cnt_nxt = 8'd0;
          trend_nxt    = TREND_APPROACH;
          tct_nxt      = item.now_ms;
        end
      end else if (fall && (trend_r == TREND_UNKNOWN || trend_r == TREND_APPROACH)) begin
        rec_cnt_nxt = rec_inc;
        if (rec_inc > cfg.confirm_count) appr_cnt_nxt = 8'd0;
        if (rec_inc > cfg.switch_count) begin
          rec_cnt_nxt = 8'd0;
          trend_nxt   = TREND_RECEDE;
          tct_nxt     = item.now_ms;
        end
      end else begin
        appr_cnt_nxt = appr_cnt_r;
      end
      last_rssi_nxt = item.rssi;
    end
  end

  // time since the last trend switch, with the timer wrap
  assign now_x = {1'b0, item.now_ms};
  assign tct_x = {1'b0, tct_nxt};
  always_comb begin
    if (now_x < tct_x) elapsed = now_x + WRAP_SPAN - tct_x;
    else               elapsed = now_x - tct_x;
  end
  assign hold_done = elapsed > HOLD_MS;

  // threshold tables
  always_comb begin
    unique case (cfg.approach_level)
      LEVEL_1: open_hit = item.rssi > OPEN_THR_1;
      LEVEL_2: open_hit = item.rssi > OPEN_THR_2;
      LEVEL_3: open_hit = item.rssi > OPEN_THR_3;
      default: open_hit = 1'b0;
    endcase
    unique case (cfg.recede_level)
      LEVEL_1: close_hit = item.rssi < CLOSE_THR_1;
      LEVEL_2: close_hit = item.rssi < CLOSE_THR_2;
      LEVEL_3: close_hit = item.rssi < CLOSE_THR_3;
      default: close_hit = 1'b0;
    endcase
  end

  // door command
  always_comb begin
    door_open_nxt   = door_open_r;
    res.event_valid = 1'b0;
    res.open_door   = 1'b0;
    res.trend       = trend_nxt;
    if (active) begin
      unique case (trend_nxt)
        TREND_APPROACH: begin
          if (open_hit && !door_open_r && hold_done) begin
            door_open_nxt   = 1'b1;
            res.event_valid = 1'b1;
            res.open_door   = 1'b1;
          end
        end
        TREND_RECEDE: begin
          if (close_hit && door_open_r && hold_done) begin
            door_open_nxt   = 1'b0;
            res.event_valid = 1'b1;
          end
        end
        default: door_open_nxt = door_open_r;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rssi_r <= '0;
      trend_r     <= TREND_UNKNOWN;
      appr_cnt_r  <= '0;
      rec_cnt_r   <= '0;
      door_open_r <= 1'b0;
      tct_r       <= '0;
    end else if (en) begin
      last_rssi_r <= last_rssi_nxt;
      trend_r     <= trend_nxt;
      appr_cnt_r  <= appr_cnt_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      door_open_r <= door_open_nxt;
      tct_r       <= tct_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rssi_proximity_door_trigger.sv
// ----------------------------------------------------------------------------
// rssi_proximity_door_trigger
// Tracks rssi trend per sample and issues open or close door commands.
// ----------------------------------------------------------------------------
// path: input beat into the input register, then trend logic into the
//   result register
// throughput: one sample per cycle while out_stall does not hold the pipeline
// reset: synchronous active-low rst_n clears trend state, pipeline valids
//   and loads the configuration defaults
`default_nettype none

module rssi_proximity_door_trigger
  import rpdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  out_t res;

  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_item_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  logic adv, in_fire;

  // pipeline advance control
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_fire)  s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    if (adv) out_valid_nxt = s1_valid_r;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_data;
    if (adv && s1_valid_r) out_data_r <= res;
  end

  rpdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpdt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv && s1_valid_r),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: sv/rpdt_checker.sv
// ----------------------------------------------------------------------------
// rpdt_checker
// Port-level checks for the rssi proximity door trigger, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rpdt_checker
  import rpdt_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  logic door_r;
  logic out_fire;

  assign out_fire = out_valid && !out_stall;

  // mirror of the door state as seen by commands
  always_ff @(posedge clk) begin
    if (!rst_n) door_r <= 1'b0;
    else if (out_fire && out_data.event_valid) door_r <= out_data.open_door;
  end

  // commands alternate, starting with open
  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_data.event_valid |-> out_data.open_door == !door_r)
    else $error("door command repeats the previous one");

  // open is only set with an event
  a_open_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.event_valid |-> !out_data.open_door)
    else $error("open_door without event_valid");

  // input never stalls while the output is empty
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind rssi_proximity_door_trigger rpdt_checker u_rpdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: test/rssi_proximity_door_trigger_tb.sv
// ----------------------------------------------------------------------------
// rssi_proximity_door_trigger_tb
// Self-checking bench for the proximity door trigger. A short directed plan
// walks reset behavior, disabled detection, threshold levels, counter
// extremes and both forms of elapsed-time wrap. Random phases then drive
// approach and recede ramps with random content and noise beats. Every
// result beat is checked against a bench-side trend and door model or a
// hand-pinned command, under random input gaps and result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_proximity_door_trigger_tb
  import rpdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 100;
  localparam out_t IDLE_UNKNOWN = '{1'b0, 1'b0, TREND_UNKNOWN};

  typedef enum logic {ROW_REGS, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_t      regs;
    in_t       beat;
    bit        pinned;
    out_t      cmd;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // command pinned by hand for some directed beats, travels with the beat
  logic pin_on;
  out_t pin_cmd;

  // bench copy of registers and tracking state
  cfg_t regs = '{1'b0, 1'b1, LEVEL_1, LEVEL_1, 8'd5, 8'd10};
  logic signed [7:0] prev_rssi = '0;
  trend_t trend_now = TREND_UNKNOWN;
  logic [7:0] approach_run = '0;
  logic [7:0] recede_run = '0;
  logic door_open = 1'b0;
  logic [TIME_W-1:0] switch_ms = '0;

  out_t door_cmd_q[$];
  plan_row_t directed_plan[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int beat_no = 0;
  bit send_burst = 1'b0;

  rssi_proximity_door_trigger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // time since the last trend switch, with the odd wrap span
  function automatic int unsigned ms_since_switch(logic [TIME_W-1:0] now);
    int unsigned t;
    t = now;
    if (now < switch_ms) t = t + WRAP_SPAN - switch_ms;
    else t = t - switch_ms;
    return t;
  endfunction

  // advance the tracking state by one sample and give the command it causes
  function automatic out_t predict_door_cmd(in_t s);
    out_t r;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (!regs.link_ready || !regs.auto_enable) begin
      approach_run = '0;
      recede_run = '0;
      r.trend = trend_now;
      return r;
    end
    // trend counting
    if (s.rssi > prev_rssi && trend_now != TREND_APPROACH) begin
      approach_run = approach_run + 8'd1;
      if (approach_run > regs.confirm_count) recede_run = '0;
      if (approach_run > regs.switch_count) begin
        approach_run = '0;
        trend_now = TREND_APPROACH;
        switch_ms = s.now_ms;
      end
    end else if (s.rssi < prev_rssi && trend_now != TREND_RECEDE) begin
      recede_run = recede_run + 8'd1;
      if (recede_run > regs.confirm_count) approach_run = '0;
      if (recede_run > regs.switch_count) begin
        recede_run = '0;
        trend_now = TREND_RECEDE;
        switch_ms = s.now_ms;
      end
    end
    prev_rssi = s.rssi;
    // door decision
    if (trend_now == TREND_APPROACH) begin
      case (regs.approach_level)
        LEVEL_1: hit = s.rssi > OPEN_THR_1;
        LEVEL_2: hit = s.rssi > OPEN_THR_2;
        LEVEL_3: hit = s.rssi > OPEN_THR_3;
        default: hit = 1'b0;
      endcase
      if (hit && !door_open && ms_since_switch(s.now_ms) > HOLD_MS) begin
        door_open = 1'b1;
        r.event_valid = 1'b1;
        r.open_door = 1'b1;
      end
    end else if (trend_now == TREND_RECEDE) begin
      case (regs.recede_level)
        LEVEL_1: hit = s.rssi < CLOSE_THR_1;
        LEVEL_2: hit = s.rssi < CLOSE_THR_2;
        LEVEL_3: hit = s.rssi < CLOSE_THR_3;
        default: hit = 1'b0;
      endcase
      if (hit && door_open && ms_since_switch(s.now_ms) > HOLD_MS) begin
        door_open = 1'b0;
        r.event_valid = 1'b1;
        r.open_door = 1'b0;
      end
    end
    r.trend = trend_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, out_t got, out_t want);
    if (mismatches < MAX_REPORTS)
      $display("%0t: result %0d %s: got ev=%0b open=%0b trend=%0d, %s",
               $realtime, beat_no, what, got.event_valid, got.open_door, got.trend,
               $sformatf("want ev=%0b open=%0b trend=%0d",
                         want.event_valid, want.open_door, want.trend));
    mismatches++;
  endtask

  // check results, predict accepted samples, track register writes, watchdog
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (door_cmd_q.size() == 0) begin
          report_mismatch("with nothing pending", out_data, '0);
        end else begin
          want = door_cmd_q.pop_front();
          if (out_data.event_valid !== want.event_valid ||
              out_data.open_door !== want.open_door ||
              out_data.trend !== want.trend)
            report_mismatch("differs", out_data, want);
        end
        beat_no++;
      end
      if (in_valid && !in_stall) begin
        want = predict_door_cmd(in_data);
        door_cmd_q.push_back(pin_on ? pin_cmd : want);
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LINK_READY:     regs.link_ready = cfg_wdata[0];
          CFG_AUTO_ENABLE:    regs.auto_enable = cfg_wdata[0];
          CFG_APPROACH_LEVEL: regs.approach_level = cfg_wdata[2:0];
          CFG_RECEDE_LEVEL:   regs.recede_level = cfg_wdata[2:0];
          CFG_CONFIRM_COUNT:  regs.confirm_count = cfg_wdata;
          CFG_SWITCH_COUNT:   regs.switch_count = cfg_wdata;
          default: ;
        endcase
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stalls, calm stretches and two long hold-offs
  initial begin : result_sink
    int pause;
    int taken;
    bit run_free;
    taken = 0;
    run_free = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) run_free = ($urandom_range(0, 2) == 0);
      if (taken == 600 || taken == 1200) pause = 64;
      else pause = run_free ? 0 : $urandom_range(0, 4);
      out_stall <= (pause > 0);
      if (pause > 0) begin
        repeat (pause) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send_sample(in_t s, bit pinned, out_t cmd);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    pin_on <= pinned;
    pin_cmd <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // drain all pending commands, then write the whole register set
  task automatic program_regs(cfg_t c);
    in_valid <= 1'b0;
    do @(posedge clk); while (door_cmd_q.size() != 0);
    put_reg(CFG_LINK_READY, CFG_DATA_W'(c.link_ready));
    put_reg(CFG_AUTO_ENABLE, CFG_DATA_W'(c.auto_enable));
    put_reg(CFG_APPROACH_LEVEL, CFG_DATA_W'(c.approach_level));
    put_reg(CFG_RECEDE_LEVEL, CFG_DATA_W'(c.recede_level));
    put_reg(CFG_CONFIRM_COUNT, c.confirm_count);
    put_reg(CFG_SWITCH_COUNT, c.switch_count);
    cfg_we <= 1'b0;
  endtask

  task automatic add_regs(cfg_t c);
    plan_row_t r;
    r = '{ROW_REGS, c, '0, 1'b0, '0};
    directed_plan.push_back(r);
  endtask

  task automatic add_beat(int dbm, int unsigned ms, bit pinned, out_t cmd);
    plan_row_t r;
    r = '{ROW_BEAT, '0, '{8'(dbm), TIME_W'(ms)}, pinned, cmd};
    directed_plan.push_back(r);
  endtask

  // random register set; holding the trend blocks every trend switch
  function automatic cfg_t draw_regs(bit hold_trend);
    cfg_t c;
    c.link_ready = hold_trend || ($urandom_range(0, 7) != 0);
    c.auto_enable = hold_trend || ($urandom_range(0, 7) != 0);
    c.approach_level = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 3))
                                                   : 3'($urandom_range(0, 7));
    c.recede_level = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 3))
                                                 : 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: c.confirm_count = 8'd0;
      1: c.confirm_count = 8'd255;
      default: c.confirm_count = 8'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 6))
      0: c.switch_count = 8'd0;
      1: c.switch_count = 8'd255;
      default: c.switch_count = 8'($urandom_range(1, 12));
    endcase
    if (hold_trend) c.switch_count = 8'd255;
    return c;
  endfunction

  // rssi ramps between near and far with random steps, or a near/far seesaw
  task automatic drive_walk(int beats, bit seesaw);
    in_t s;
    int dbm;
    int goal;
    int step;
    logic [TIME_W-1:0] clock_ms;
    dbm = -int'($urandom_range(80, 110));
    goal = -int'($urandom_range(15, 45));
    if ($urandom_range(0, 2) == 0)
      clock_ms = TIME_W'(WRAP_SPAN) - TIME_W'($urandom_range(0, 20000));
    else clock_ms = TIME_W'($urandom);
    for (int i = 0; i < beats; i++) begin
      clock_ms = clock_ms + TIME_W'($urandom_range(20, 300));
      if (seesaw) begin
        dbm = (i % 2 != 0) ? -int'($urandom_range(20, 40)) : -int'($urandom_range(90, 110));
      end else begin
        if (dbm == goal)
          goal = (goal > -60) ? -int'($urandom_range(100, 115)) : -int'($urandom_range(15, 45));
        step = $urandom_range(0, 4);
        if (goal > dbm) dbm = (dbm + step > goal) ? goal : dbm + step;
        else dbm = (dbm - step < goal) ? goal : dbm - step;
      end
      s.rssi = 8'(dbm);
      s.now_ms = clock_ms;
      // noise beats: any sample, sometimes any time
      if ($urandom_range(0, 6) == 0) begin
        s.rssi = 8'($urandom);
        if ($urandom_range(0, 1) == 0) s.now_ms = TIME_W'($urandom);
      end
      send_sample(s, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    plan_row_t r;
    in_valid <= 1'b0;
    in_data <= '0;
    pin_on <= 1'b0;
    pin_cmd <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset the link is down: nothing counts, trend unknown
    add_beat(127, 32'h7FF_FFFF, 1'b1, IDLE_UNKNOWN);
    add_beat(-128, 0, 1'b1, IDLE_UNKNOWN);
    // link up but auto control off
    add_regs('{1'b1, 1'b0, LEVEL_1, LEVEL_1, 8'd5, 8'd10});
    add_beat(0, 5, 1'b1, IDLE_UNKNOWN);
    // zero counts: every move against the trend switches it
    add_regs('{1'b1, 1'b1, LEVEL_3, LEVEL_3, 8'd0, 8'd0});
    add_beat(-128, 100, 1'b0, '0);
    add_beat(-128, 200, 1'b0, '0);          // equal sample
    add_beat(-60, 300, 1'b0, '0);
    add_beat(-60, 1300, 1'b0, '0);          // exactly the hold time
    add_beat(-60, 1301, 1'b0, '0);          // opens
    add_beat(-60, 5000, 1'b0, '0);
    add_beat(127, 6000, 1'b0, '0);
    add_beat(-100, 32'h4FF_FF00, 1'b0, '0);
    add_beat(-100, 32'h100, 1'b0, '0);      // wrapped, still short
    add_beat(-100, 32'h300, 1'b0, '0);      // wrapped, long enough to close
    add_beat(-20, 32'h7FF_FF00, 1'b0, '0);
    add_beat(-20, 32'h10, 1'b0, '0);        // wrap below the switch time
    // levels out of range never fire, counts at their top
    add_regs('{1'b1, 1'b1, 3'd0, 3'd4, 8'd255, 8'd255});
    add_beat(-128, 32'h2AA_AAAA, 1'b0, '0);
    add_beat(127, 32'h555_5555, 1'b0, '0);
    add_beat(-1, 32'h123_4567, 1'b0, '0);
    // middle levels on a short ramp
    add_regs('{1'b1, 1'b1, LEVEL_2, LEVEL_2, 8'd1, 8'd2});
    add_beat(-70, 20000, 1'b0, '0);
    add_beat(-75, 20100, 1'b0, '0);
    add_beat(-80, 20200, 1'b0, '0);
    add_beat(-91, 20300, 1'b0, '0);
    add_beat(-95, 21500, 1'b0, '0);
    add_beat(-60, 22000, 1'b0, '0);

    foreach (directed_plan[i]) begin
      r = directed_plan[i];
      if (r.kind == ROW_REGS) program_regs(r.regs);
      else send_sample(r.beat, r.pinned, r.cmd);
    end

    // seesaw with no trend switch so a counter can run past 255 and wrap
    program_regs(draw_regs(1'b1));
    drive_walk(520, 1'b1);

    // random phases
    for (int p = 0; p < 10; p++) begin
      send_burst = ($urandom_range(0, 3) == 0);
      program_regs(draw_regs(1'b0));
      drive_walk(130, 1'b0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (door_cmd_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
